[rtl/core/bcrq_pkg.sv]
package bcrq_pkg;

    // register indexes on the configuration channel
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_ACCUM_SHIFT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BIAS_SCALE  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FINAL_SHIFT = 2'd2;
    localparam int CfgDataW = 16;

    typedef struct packed {
        logic signed [5:0]  accum_shift;
        logic signed [15:0] bias_scale;
        logic signed [5:0]  final_shift;
    } t_cfg;

    // one table entry: multiplier and bias of a channel
    typedef struct packed {
        logic signed [15:0] mul;
        logic signed [15:0] bias;
    } t_coef;

endpackage

[rtl/core/bcrq_if.sv]
interface bcrq_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [7:0]         channel;
    logic signed [31:0] accumulator;
    logic signed [15:0] load_multiplier;
    logic signed [15:0] load_bias;

    modport source (output valid, mode, channel, accumulator, load_multiplier, load_bias,
                    input ready);
    modport sink   (input valid, mode, channel, accumulator, load_multiplier, load_bias,
                    output ready);
endinterface

interface bcrq_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] activation;

    modport source (output valid, activation, input ready);
    modport sink   (input valid, activation, output ready);
endinterface

interface bcrq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/bcrq_cfg_regs.sv]
module bcrq_cfg_regs
    import bcrq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcrq_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ACCUM_SHIFT: n_cfg.accum_shift = i_cfg.data[5:0];
                CFG_BIAS_SCALE:  n_cfg.bias_scale  = i_cfg.data;
                CFG_FINAL_SHIFT: n_cfg.final_shift = i_cfg.data[5:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accum_shift <= 6'sd0;
            r_cfg.bias_scale  <= 16'sd1;
            r_cfg.final_shift <= 6'sd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/bcrq_coef_mem.sv]
module bcrq_coef_mem
    import bcrq_pkg::*;
#(
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_coef         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_coef         o_rd_data
);

    t_coef r_mem [DEPTH];
    t_coef r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data is held while the pipeline stage behind it stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/core/bcrq_requant_pipe.sv]
module bcrq_requant_pipe
    import bcrq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_accumulator,
    input  logic               i_ch_ok,
    input  t_coef              i_coef,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [7:0]  o_activation
);

    // rounded shift (left for a count <= 0), then symmetric saturation to 16 bits
    function automatic logic signed [15:0] rshift_sat16(input logic signed [32:0] v,
                                                        input logic signed [5:0]  s);
        logic signed [33:0] t;
        logic signed [33:0] half;
        logic signed [65:0] w;
        logic [5:0]         rnd;
        logic [6:0]         k;
        logic signed [15:0] res;
        t    = '0;
        half = '0;
        w    = '0;
        rnd  = '0;
        k    = '0;
        if (s > 6'sd0) begin
            rnd  = 6'(s) - 6'd1;
            half = 34'sd1 <<< rnd;
            t    = {v[32], v} + half;
            t    = t >>> s[4:0];
            if (t > 34'sd32767) begin
                res = 16'sd32767;
            end else if (t < -34'sd32767) begin
                res = -16'sd32767;
            end else begin
                res = t[15:0];
            end
        end else begin
            k = 7'd0 - {s[5], s};
            w = {{33{v[32]}}, v};
            w = w <<< k;
            if (w > 66'sd32767) begin
                res = 16'sd32767;
            end else if (w < -66'sd32767) begin
                res = -16'sd32767;
            end else begin
                res = w[15:0];
            end
        end
        return res;
    endfunction

    logic adv1, adv2, adv3, adv4;

    logic               r_v1, r_ok1;
    logic signed [15:0] r_scaled1;
    logic               r_v2;
    logic signed [31:0] r_prod2, r_bias2;
    logic               r_v3;
    logic signed [31:0] r_sum3;
    logic               r_v4;
    logic signed [7:0]  r_act4;

    logic signed [15:0] n_scaled1;
    logic signed [15:0] w_mul, w_bias;
    logic signed [31:0] n_prod2, n_bias2;
    logic signed [32:0] w_sum;
    logic signed [31:0] n_sum3;
    logic signed [15:0] w_p16;
    logic signed [16:0] w_r8;
    logic signed [16:0] w_q;
    logic signed [7:0]  n_act4;

    // each stage moves when it is empty or the stage after it moves
    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    assign o_valid      = r_v4;
    assign o_activation = r_act4;

    always_comb begin
        n_scaled1 = rshift_sat16({i_accumulator[31], i_accumulator}, i_cfg.accum_shift);
        w_mul     = r_ok1 ? i_coef.mul  : 16'sd0;
        w_bias    = r_ok1 ? i_coef.bias : 16'sd0;
        n_prod2   = w_mul * r_scaled1;
        n_bias2   = w_bias * i_cfg.bias_scale;
        w_sum     = {r_prod2[31], r_prod2} + {r_bias2[31], r_bias2};
        if (w_sum > 33'sd2147483647) begin
            n_sum3 = 32'sh7FFF_FFFF;
        end else if (w_sum < -33'sd2147483647) begin
            n_sum3 = 32'sh8000_0001;
        end else begin
            n_sum3 = w_sum[31:0];
        end
        w_p16 = rshift_sat16({r_sum3[31], r_sum3}, i_cfg.final_shift);
        w_r8  = {w_p16[15], w_p16} + 17'sd128;
        w_q   = w_r8 >>> 8;
        if (w_q > 17'sd127) begin
            n_act4 = 8'sd127;
        end else begin
            n_act4 = w_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_scaled1 <= n_scaled1;
            r_ok1     <= i_ch_ok;
        end
        if (adv2) begin
            r_prod2 <= n_prod2;
            r_bias2 <= n_bias2;
        end
        if (adv3) begin
            r_sum3 <= n_sum3;
        end
        if (adv4) begin
            r_act4 <= n_act4;
        end
    end

endmodule

[rtl/core/binary_conv_post_activation_requant.sv]
// Per-channel requantizer for binary convolution: each compute word turns a signed
// 32-bit accumulator into one signed 8-bit activation using the channel's multiplier
// and bias from an on-chip coefficient memory; each load word writes one channel's
// multiplier and bias and gives no result. One word is accepted per cycle while the
// input is ready, loads and computes freely mixed, and a compute word's activation is
// held at the output until taken. There are four register stages:
// accumulator shift/saturate together with the coefficient memory read, then multiply,
// add/saturate and final shift/round. The input stalls only while a result waits at
// the output. A load is visible to a compute word on the very next cycle.
// The coefficient memory is not cleared: computing on a channel never loaded gives an
// undefined activation. Channels at or above CHANNELS ignore loads and compute with
// zero multiplier and bias. Configuration words may be written only while idle.
module binary_conv_post_activation_requant
    import bcrq_pkg::*;
#(
    parameter  int CHANNELS = 256,
    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcrq_in_if.sink    i_in,
    bcrq_out_if.source o_out,
    bcrq_cfg_if.sink   i_cfg
);

    t_cfg          w_cfg;
    t_coef         w_wr_coef;
    t_coef         w_rd_coef;
    logic          w_ch_ok;
    logic          w_in_ready;
    logic          w_wr_en;
    logic [AW-1:0] w_addr;

    // channel range check; out of range loads are dropped
    assign w_ch_ok = (32'(i_in.channel) < CHANNELS);
    assign w_addr  = AW'(i_in.channel);

    assign i_in.ready = w_in_ready;

    // load word: write the table entry in the accept cycle
    assign w_wr_en        = i_in.valid && w_in_ready && !i_in.mode && w_ch_ok;
    assign w_wr_coef.mul  = i_in.load_multiplier;
    assign w_wr_coef.bias = i_in.load_bias;

    bcrq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // read runs in step with the first pipeline stage so the data lines up with it
    bcrq_coef_mem #(
        .DEPTH (CHANNELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wr_coef),
        .i_rd_en   (w_in_ready),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_coef)
    );

    // only compute words enter the pipeline
    bcrq_requant_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid && i_in.mode),
        .o_ready       (w_in_ready),
        .i_accumulator (i_in.accumulator),
        .i_ch_ok       (w_ch_ok),
        .i_coef        (w_rd_coef),
        .i_cfg         (w_cfg),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_activation  (o_out.activation)
    );

endmodule

[rtl/core/bcrq_checker.sv]
module bcrq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_activation
);

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_activation))
        else $error("result word changed while stalled");

    // the input side only stalls when a result is stuck at the output
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with output free");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word after reset");

endmodule

bind binary_conv_post_activation_requant bcrq_checker u_bcrq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_activation (o_out.activation)
);
